// File: sv/adi_pkg.sv
// Shared constants, types and elaboration-time ROM builders for the density interpolator.
package adi_pkg;

    localparam int TABLE_POINTS = 30;
    localparam int FRAC_BITS    = 15;
    localparam int LOG_BITS     = 30;
    localparam int REF_DEN      = 2688;

    // Field widths
    localparam int ALT_W       = 18;
    localparam int MANT_W      = 16;
    localparam int SHIFT_W     = 5;
    localparam int SEG_W       = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MANT_W - SHIFT_W - SEG_W;

    // Datapath widths
    localparam int DIST_W     = 14;                 // widest segment is 10000 m
    localparam int NL_W       = FRAC_BITS + SHIFT_W;
    localparam int DN_W       = FRAC_BITS + 2;      // log2 step per segment stays below 4
    localparam int RW_W       = 21;                 // 2^32 / 4000 m rounds under 2^21
    localparam int M1_W       = DN_W + DIST_W;
    localparam int M2_W       = M1_W + RW_W;
    localparam int P_W        = 32;                 // Q1.31 product
    localparam int TAB_BITS   = (FRAC_BITS > 8) ? 8 : FRAC_BITS - 1;
    localparam int TAB_SIZE   = 2 ** TAB_BITS;
    localparam int MUL_STAGES = FRAC_BITS - TAB_BITS;

    localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << (MANT_W - 1);

    localparam logic [ALT_W-1:0] ALT_M [TABLE_POINTS] = '{
        0, 5000, 10000, 15000, 20000, 25000, 30000, 35000, 40000, 45000,
        50000, 55000, 60000, 64000, 68000, 72000, 76000, 80000, 84000, 88000,
        92000, 96000, 100000, 108000, 114000, 120000, 126000, 132000, 140000, 150000};

    // density = DENS_M * 10^(16 - DENS_D)
    localparam int unsigned DENS_M [TABLE_POINTS] = '{
        2688, 1530, 8590, 4050, 1850, 8330, 3830, 1760, 8310, 4088,
        2130, 1181, 6330, 3930, 2390, 1390, 7720, 4030, 1990, 9480,
        4370, 2070, 1040, 3180, 1430, 6610, 3400, 1910, 9700, 4920};
    localparam int unsigned DENS_D [TABLE_POINTS] = '{
        0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 6,
        6, 6, 6, 7, 7, 8, 8, 8, 9, 9};

    typedef logic [TABLE_POINTS-1:0][NL_W-1:0] t_nl_rom;
    typedef logic [TABLE_POINTS-2:0][DN_W-1:0] t_dn_rom;
    typedef logic [TABLE_POINTS-2:0][RW_W-1:0] t_rw_rom;
    typedef logic [FRAC_BITS:1][P_W-1:0]       t_c_rom;
    typedef logic [TAB_SIZE-1:0][P_W-1:0]      t_p_tab;

    typedef struct packed {
        logic             vld;
        logic             oor;
        logic [SEG_W-1:0] seg;
        logic [NL_W-1:0]  nl;     // -log2(ratio), Q.FRAC_BITS
    } t_nl_item;

    typedef struct packed {
        logic [MANT_W-1:0]  mant;
        logic [SHIFT_W-1:0] shift;
        logic [SEG_W-1:0]   seg;
        logic               oor;
    } t_result;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = '0;
        bit_v = 64'h1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n   = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // restoring shift-subtract quotient
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // log2(num/den) in Q.FRAC_BITS, num >= den > 0
    function automatic logic [63:0] log2_ratio(input logic [63:0] num, input logic [63:0] den);
        int          k;
        logic [63:0] d;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] v;
        k = 0;
        while (k < 62 && ((den << (k + 1)) <= num)) k++;
        d   = den << k;
        rem = num - d;
        x   = 64'h1;
        for (int b = 0; b < 31; b++) begin
            rem = rem << 1;
            x   = x << 1;
            if (rem >= d) begin
                rem = rem - d;
                x   = x | 64'h1;
            end
        end
        acc = '0;
        for (int b = 0; b < LOG_BITS; b++) begin
            x   = (x * x) >> 31;
            acc = acc << 1;
            if (x >= (64'h1 << 32)) begin
                acc = acc | 64'h1;
                x   = x >> 1;
            end
        end
        v = (64'(k) << LOG_BITS) | acc;
        return (v + (64'h1 << (LOG_BITS - FRAC_BITS - 1))) >> (LOG_BITS - FRAC_BITS);
    endfunction

    function automatic t_nl_rom calc_nl();
        t_nl_rom     r;
        logic [63:0] num;
        logic [63:0] v;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            num = 64'(REF_DEN);
            for (int j = 0; j < int'(DENS_D[i]); j++) num = num * 64'd10;
            v    = log2_ratio(num, 64'(DENS_M[i]));
            r[i] = v[NL_W-1:0];
        end
        return r;
    endfunction

    function automatic t_dn_rom calc_dn();
        t_nl_rom nl;
        t_dn_rom r;
        nl = calc_nl();
        for (int i = 0; i < TABLE_POINTS - 1; i++) r[i] = DN_W'(nl[i+1] - nl[i]);
        return r;
    endfunction

    function automatic t_rw_rom calc_rw();
        t_rw_rom     r;
        logic [63:0] w;
        logic [63:0] q;
        for (int i = 0; i < TABLE_POINTS - 1; i++) begin
            w    = 64'(ALT_M[i+1] - ALT_M[i]);
            q    = udiv64((64'h1 << 32) + (w >> 1), w);
            r[i] = q[RW_W-1:0];
        end
        return r;
    endfunction

    // c[k] = 2^(2^-k) in Q1.31
    function automatic t_c_rom calc_c();
        t_c_rom      r;
        logic [63:0] c;
        c = 64'h1 << 32;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            c    = isqrt64(c << 31);
            r[k] = c[P_W-1:0];
        end
        return r;
    endfunction

    // product chain for the top TAB_BITS bits of g, starting from 1.0
    function automatic t_p_tab calc_p_tab();
        t_c_rom      c;
        t_p_tab      r;
        logic [63:0] p;
        c = calc_c();
        for (int idx = 0; idx < TAB_SIZE; idx++) begin
            p = 64'h1 << 31;
            for (int k = 1; k <= TAB_BITS; k++) begin
                if (((idx >> (TAB_BITS - k)) & 1) != 0)
                    p = (p * 64'(c[k]) + (64'h1 << 30)) >> 31;
            end
            r[idx] = p[P_W-1:0];
        end
        return r;
    endfunction

    localparam t_nl_rom NL_ROM = calc_nl();
    localparam t_dn_rom DN_ROM = calc_dn();
    localparam t_rw_rom RW_ROM = calc_rw();
    localparam t_c_rom  C_ROM  = calc_c();
    localparam t_p_tab  P_TAB  = calc_p_tab();

    localparam logic [2*P_W-1:0] HALF_Q31 = (2*P_W)'(1) << (P_W - 2);
    localparam logic [M2_W:0]    HALF_Q32 = (M2_W+1)'(1) << 31;

endpackage

// File: sv/adi_interp.sv
// Segment search and log-domain linear interpolation, five register stages.
module adi_interp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [adi_pkg::ALT_W-1:0]   i_alt,
    output adi_pkg::t_nl_item           o_item
);
    import adi_pkg::*;

    // stage A: segment and range
    logic             r_a_vld, r_a_oor;
    logic [ALT_W-1:0] r_a_alt;
    logic [SEG_W-1:0] r_a_seg, n_a_seg;
    logic             n_a_oor;

    always_comb begin
        n_a_oor = i_alt > ALT_M[TABLE_POINTS-1];
        n_a_seg = '0;
        for (int i = 1; i < TABLE_POINTS - 1; i++) begin
            if (ALT_M[i] <= i_alt) n_a_seg = SEG_W'(i);
        end
    end

    // stage B: offset into segment and ROM reads
    logic              r_b_vld, r_b_oor;
    logic [SEG_W-1:0]  r_b_seg;
    logic [DIST_W-1:0] r_b_dist, n_b_dist;
    logic [NL_W-1:0]   r_b_nl0;
    logic [DN_W-1:0]   r_b_dn;
    logic [RW_W-1:0]   r_b_rw;

    assign n_b_dist = DIST_W'(r_a_alt - ALT_M[r_a_seg]);

    // stage C: dn * dist
    logic              r_c_vld, r_c_oor;
    logic [SEG_W-1:0]  r_c_seg;
    logic [NL_W-1:0]   r_c_nl0;
    logic [RW_W-1:0]   r_c_rw;
    logic [M1_W-1:0]   r_c_m1, n_c_m1;

    assign n_c_m1 = M1_W'(r_b_dn) * M1_W'(r_b_dist);

    // stage D: times reciprocal width
    logic              r_d_vld, r_d_oor;
    logic [SEG_W-1:0]  r_d_seg;
    logic [NL_W-1:0]   r_d_nl0;
    logic [M2_W-1:0]   r_d_m2, n_d_m2;

    assign n_d_m2 = M2_W'(r_c_m1) * M2_W'(r_c_rw);

    // stage E: round and add base
    logic              r_e_vld, r_e_oor;
    logic [SEG_W-1:0]  r_e_seg;
    logic [NL_W-1:0]   r_e_nl, n_e_nl;
    logic [M2_W:0]     rnd_sum;

    assign rnd_sum = {1'b0, r_d_m2} + HALF_Q32;
    assign n_e_nl  = r_d_nl0 + NL_W'(rnd_sum[M2_W:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_alt  <= i_alt;
            r_a_seg  <= n_a_seg;
            r_a_oor  <= n_a_oor;

            r_b_seg  <= r_a_seg;
            r_b_oor  <= r_a_oor;
            r_b_dist <= n_b_dist;
            r_b_nl0  <= NL_ROM[r_a_seg];
            r_b_dn   <= DN_ROM[r_a_seg];
            r_b_rw   <= RW_ROM[r_a_seg];

            r_c_seg  <= r_b_seg;
            r_c_oor  <= r_b_oor;
            r_c_nl0  <= r_b_nl0;
            r_c_rw   <= r_b_rw;
            r_c_m1   <= n_c_m1;

            r_d_seg  <= r_c_seg;
            r_d_oor  <= r_c_oor;
            r_d_nl0  <= r_c_nl0;
            r_d_m2   <= n_d_m2;

            r_e_seg  <= r_d_seg;
            r_e_oor  <= r_d_oor;
            r_e_nl   <= n_e_nl;
        end
    end

    assign o_item.vld = r_e_vld;
    assign o_item.oor = r_e_oor;
    assign o_item.seg = r_e_seg;
    assign o_item.nl  = r_e_nl;

endmodule

// File: sv/adi_exp2.sv
// 2^-nl as mantissa and shift: table lookup, multiply chain, final rounding.
module adi_exp2 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  adi_pkg::t_nl_item i_item,
    output logic              o_vld,
    output adi_pkg::t_result  o_res
);
    import adi_pkg::*;

    localparam int NS = MUL_STAGES + 1;

    logic [FRAC_BITS-1:0] frac, g;
    logic [P_W-1:0]        n_f_p;

    assign frac  = i_item.nl[FRAC_BITS-1:0];
    assign g     = FRAC_BITS'(0) - frac;      // 2^FRAC_BITS - f
    assign n_f_p = P_TAB[g[FRAC_BITS-1 -: TAB_BITS]];

    // element 0 is the table stage, then one element per multiply stage
    logic                  r_m_vld [NS];
    logic                  r_m_oor [NS];
    logic                  r_m_fz  [NS];
    logic [SEG_W-1:0]      r_m_seg [NS];
    logic [SHIFT_W-1:0]    r_m_sh  [NS];
    logic [MUL_STAGES-1:0] r_m_glo [NS];
    logic [P_W-1:0]        r_m_p   [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_m_vld[0] <= i_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_oor[0] <= i_item.oor;
            r_m_fz[0]  <= (frac == '0);
            r_m_seg[0] <= i_item.seg;
            r_m_sh[0]  <= i_item.nl[NL_W-1:FRAC_BITS];
            r_m_glo[0] <= g[MUL_STAGES-1:0];
            r_m_p[0]   <= n_f_p;
        end
    end

    for (genvar j = 0; j < MUL_STAGES; j++) begin : g_mul
        logic [2*P_W-1:0] prod;
        logic [2*P_W-1:0] sum;
        logic [P_W-1:0]   n_p;

        always_comb begin
            prod = (2*P_W)'(r_m_p[j]) * (2*P_W)'(C_ROM[TAB_BITS + 1 + j]);
            sum  = prod + HALF_Q31;
            n_p  = r_m_glo[j][MUL_STAGES-1-j] ? sum[2*P_W-2:P_W-1] : r_m_p[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_m_vld[j+1] <= r_m_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m_oor[j+1] <= r_m_oor[j];
                r_m_fz[j+1]  <= r_m_fz[j];
                r_m_seg[j+1] <= r_m_seg[j];
                r_m_sh[j+1]  <= r_m_sh[j];
                r_m_glo[j+1] <= r_m_glo[j];
                r_m_p[j+1]   <= n_p;
            end
        end
    end

    // final rounding to Q1.15
    logic [P_W-1:0]   p_last;
    logic [MANT_W:0]  mant_rnd;
    t_result          n_res;
    t_result          r_res;
    logic             r_vld;

    assign p_last   = r_m_p[MUL_STAGES];
    assign mant_rnd = {1'b0, p_last[P_W-1 -: MANT_W]} + (MANT_W+1)'(p_last[P_W-MANT_W-1]);

    always_comb begin
        n_res.seg = r_m_seg[MUL_STAGES];
        n_res.oor = 1'b0;
        if (r_m_oor[MUL_STAGES]) begin
            n_res.mant  = '0;
            n_res.shift = '0;
            n_res.seg   = '0;
            n_res.oor   = 1'b1;
        end else if (r_m_fz[MUL_STAGES] || mant_rnd[MANT_W]) begin
            // exact power of two, or rounding carried into the next octave
            n_res.mant  = MANT_ONE;
            n_res.shift = r_m_sh[MUL_STAGES];
        end else begin
            n_res.mant  = mant_rnd[MANT_W-1:0];
            n_res.shift = r_m_sh[MUL_STAGES] + SHIFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_m_vld[MUL_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

// File: sv/atmosphere_density_interp_core.sv
// Top level: stream ports, interpolation and exponent pipelines, output skid register.
//
// Takes one altitude in metres per clock, while s_axis_tready is high, and returns the
// standard-atmosphere density ratio to sea level as a Q1.15 mantissa and a right shift,
// plus the lower table segment. Altitudes above 150000 m return the out-of-range flag
// with all other fields zero. Fully pipelined: one transaction per cycle sustained
// while the sink accepts. The path runs through the two interpolation multipliers and
// the seven-stage Q1.31 multiply chain that forms 2^-x. All stages move on one shared
// enable; a one-entry skid register behind the last stage holds a result the sink has
// not taken, and s_axis_tready drops only while that register is occupied.
module atmosphere_density_interp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [adi_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [17:0] altitude_m
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [adi_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [15:0] density_mantissa,
                                                               // [20:16] density_shift,
                                                               // [25:21] segment_index
    output logic                                m_axis_tuser   // out_of_range
);
    import adi_pkg::*;

    logic     en;
    t_nl_item nl_item;
    logic     pipe_vld;
    t_result  pipe_res;
    logic     r_skid_vld;
    t_result  r_skid_res;
    t_result  out_res;

    assign en            = !r_skid_vld;
    assign s_axis_tready = !r_skid_vld;

    adi_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_alt   (s_axis_tdata[ALT_W-1:0]),
        .o_item  (nl_item)
    );

    adi_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (nl_item),
        .o_vld   (pipe_vld),
        .o_res   (pipe_res)
    );

    // catch the last stage when the sink stalls, since the pipeline moves on this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            r_skid_vld <= pipe_vld && !m_axis_tready;
        end else if (m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_res <= pipe_res;
        end
    end

    assign out_res       = r_skid_vld ? r_skid_res : pipe_res;
    assign m_axis_tvalid = r_skid_vld || pipe_vld;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_res.seg, out_res.shift, out_res.mant};
    assign m_axis_tuser  = out_res.oor;

endmodule

// File: tb/adi_density_checker.sv
// Checker for the density interpolator: predicts each result from the altitude and compares.
`timescale 1ns / 1ps

module adi_density_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [adi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [17:0] altitude_m
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [adi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [15:0] density_mantissa,
                                                               // [20:16] density_shift,
                                                               // [25:21] segment_index
    input  logic                               m_axis_tuser,   // out_of_range
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import adi_pkg::*;

    localparam int NPTS     = TABLE_POINTS;
    localparam int FB       = FRAC_BITS;

    localparam int unsigned ALT_POINTS [NPTS] = '{
        0, 5000, 10000, 15000, 20000, 25000, 30000, 35000, 40000, 45000,
        50000, 55000, 60000, 64000, 68000, 72000, 76000, 80000, 84000, 88000,
        92000, 96000, 100000, 108000, 114000, 120000, 126000, 132000, 140000, 150000};
    // density at point i = DENS_DIGITS[i] * 10^(16 - DENS_DECADES[i])
    localparam int unsigned DENS_DIGITS [NPTS] = '{
        2688, 1530, 8590, 4050, 1850, 8330, 3830, 1760, 8310, 4088,
        2130, 1181, 6330, 3930, 2390, 1390, 7720, 4030, 1990, 9480,
        4370, 2070, 1040, 3180, 1430, 6610, 3400, 1910, 9700, 4920};
    localparam int unsigned DENS_DECADES [NPTS] = '{
        0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 6,
        6, 6, 6, 7, 7, 8, 8, 8, 9, 9};
    localparam int unsigned SEA_LEVEL_DIGITS = 2688;

    typedef struct {
        logic [ALT_W-1:0] alt;
        t_result          res;
    } t_density_expect;

    logic [63:0] neg_log_tab [NPTS];     // -log2(ratio) per point, Q.FB
    logic [63:0] inv_width_tab [NPTS];   // 2^32 / segment width, rounded
    logic [63:0] root_tab [FB+1];        // 2^(2^-k), Q1.31

    t_density_expect density_due [$];
    int              mismatches = 0;
    int              due_count  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = due_count;

    function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        lo = '0;
        hi = 128'd1 << 33;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        return lo[63:0];
    endfunction

    // log2(num/den) via normalize + repeated squaring, 30 fraction bits, rounded to FB
    function automatic logic [63:0] log2_of_ratio(input logic [63:0] num, input logic [63:0] den);
        int           octave;
        logic [127:0] x;
        logic [63:0]  bits;
        logic [63:0]  v;
        octave = 0;
        while (octave < 62 && ((den << (octave + 1)) <= num)) octave++;
        x    = ({64'd0, num} << 31) / ({64'd0, den} << octave);
        bits = '0;
        for (int b = 0; b < 30; b++) begin
            x    = (x * x) >> 31;
            bits = bits << 1;
            if (x >= (128'd1 << 32)) begin
                bits = bits | 64'd1;
                x    = x >> 1;
            end
        end
        v = (64'(octave) << 30) | bits;
        return (v + (64'd1 << (30 - FB - 1))) >> (30 - FB);
    endfunction

    initial begin
        logic [63:0] num;
        logic [63:0] w;
        for (int i = 0; i < NPTS; i++) begin
            num = 64'(SEA_LEVEL_DIGITS);
            repeat (DENS_DECADES[i]) num = num * 64'd10;
            neg_log_tab[i] = log2_of_ratio(num, 64'(DENS_DIGITS[i]));
            if (i + 1 < NPTS) begin
                w                = 64'(ALT_POINTS[i+1] - ALT_POINTS[i]);
                inv_width_tab[i] = ((64'd1 << 32) + (w >> 1)) / w;
            end else begin
                inv_width_tab[i] = '0;
            end
        end
        root_tab[0] = 64'd1 << 32;
        for (int k = 1; k <= FB; k++)
            root_tab[k] = floor_sqrt({64'd0, root_tab[k-1]} << 31);
    end

    function automatic t_result predict_density(input logic [ALT_W-1:0] h);
        t_result     r;
        int          seg;
        logic [63:0] offset;
        logic [63:0] step;
        logic [63:0] nl;
        logic [63:0] frac;
        logic [63:0] g;
        logic [63:0] p;
        logic [63:0] mant;
        logic [63:0] shift;
        r = '0;
        if (h > ALT_POINTS[NPTS-1]) begin
            r.oor = 1'b1;
            return r;
        end
        // the top point belongs to the last segment
        seg = 0;
        for (int i = 1; i < NPTS - 1; i++)
            if (ALT_POINTS[i] <= h) seg = i;
        offset = 64'(h) - 64'(ALT_POINTS[seg]);
        step   = neg_log_tab[seg+1] - neg_log_tab[seg];
        nl     = neg_log_tab[seg] + ((step * offset * inv_width_tab[seg] + (64'd1 << 31)) >> 32);
        frac   = nl & ((64'd1 << FB) - 1);
        if (frac == 0) begin
            mant  = 64'd32768;
            shift = nl >> FB;
        end else begin
            g = (64'd1 << FB) - frac;
            p = 64'd1 << 31;
            for (int k = 1; k <= FB; k++)
                if (g[FB-k]) p = (p * root_tab[k] + (64'd1 << 30)) >> 31;
            mant  = (p + (64'd1 << 15)) >> 16;
            shift = (nl >> FB) + 1;
            if (mant >= 64'd65536) begin
                mant  = 64'd32768;
                shift = shift - 1;
            end
        end
        r.mant  = mant[MANT_W-1:0];
        r.shift = shift[SHIFT_W-1:0];
        r.seg   = SEG_W'(seg);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [ALT_W-1:0] alt);
        if (got !== want) begin
            $display("%0t: %s mismatch, altitude %0d: expected %0d, actual %0d",
                     $time, name, alt, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_density_expect want;
        if (i_rst_n) begin
            // retire first, so a result never matches an item taken on the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (density_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = density_due.pop_front();
                    check_field("density_mantissa", 32'(m_axis_tdata[15:0]),
                                32'(want.res.mant), want.alt);
                    check_field("density_shift", 32'(m_axis_tdata[20:16]),
                                32'(want.res.shift), want.alt);
                    check_field("segment_index", 32'(m_axis_tdata[25:21]),
                                32'(want.res.seg), want.alt);
                    check_field("out_of_range", 32'(m_axis_tuser), 32'(want.res.oor), want.alt);
                    check_field("tdata padding", 32'(m_axis_tdata[OUT_TDATA_W-1:26]), 32'd0,
                                want.alt);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want.alt = s_axis_tdata[ALT_W-1:0];
                want.res = predict_density(want.alt);
                density_due.push_back(want);
            end
            due_count <= density_due.size();
        end
    end

endmodule

// File: tb/atmosphere_density_interp_core_test.sv
// Testbench top: clock, reset, altitude stimulus, output back-pressure and final verdict.
`timescale 1ns / 1ps

module atmosphere_density_interp_core_test;
    import adi_pkg::*;

    localparam int RANDOM_ITEMS = 1880;
    localparam int CALM_ITEMS   = 300;
    localparam int SQUEEZE_AT   = 600;
    localparam int SQUEEZE_LEN  = 60;
    localparam int PAUSE_AT     = 1200;
    localparam int LONG_STALL   = 80;
    localparam int DRAIN_LIMIT  = 5000;

    localparam int unsigned EDGE_ALTS [22] = '{
        0, 1, 2, 4999, 5000, 5001, 10000, 59999, 60000, 64000, 65535,
        86000, 99999, 100000, 108000, 131071, 140000, 149999, 150000, 150001,
        196608, 262143};

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                      m_axis_tuser;

    logic                      calm_phase     = 1'b0;
    logic                      stall_request  = 1'b0;
    logic                      stall_served   = 1'b0;
    int                        fail_count;
    int                        due_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    atmosphere_density_interp_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    adi_density_checker density_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (due_count)
    );

    task automatic offer_altitude(input logic [ALT_W-1:0] alt);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ALT_W){1'b0}}, alt};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // mostly uniform over the table, some just around table points, some above range
    function automatic logic [ALT_W-1:0] random_altitude();
        int pick;
        int pt;
        int alt;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            alt = $urandom_range(150001, 262143);
        end else if (pick < 25) begin
            pt  = $urandom_range(0, TABLE_POINTS - 1);
            alt = int'(ALT_M[pt]) + $urandom_range(0, 6) - 3;
            if (alt < 0) alt = 0;
        end else begin
            alt = $urandom_range(0, 150000);
        end
        return ALT_W'(alt);
    endfunction

    initial begin
        int drain_wait;
        drain_wait = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(EDGE_ALTS); i++)
            offer_altitude(ALT_W'(EDGE_ALTS[i]));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == SQUEEZE_AT) stall_request <= 1'b1;
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm_phase <= 1'b1;
            if (n == PAUSE_AT) begin
                // let the pipeline run dry before carrying on
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (due_count != 0) @(posedge i_clk);
            end else if (n < RANDOM_ITEMS - CALM_ITEMS &&
                         (n < SQUEEZE_AT || n >= SQUEEZE_AT + SQUEEZE_LEN) &&
                         $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            offer_altitude(random_altitude());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (due_count != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (40) @(posedge i_clk);
        if (due_count != 0)
            $display("%0t: %0d results never arrived", $time, due_count);
        if (fail_count == 0 && due_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // sink side: random back-pressure, one long hold-off to fill the pipeline
    initial begin
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (stall_request && !stall_served) begin
                stall_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/adi_pkg.sv
sv/adi_interp.sv
sv/adi_exp2.sv
sv/atmosphere_density_interp_core.sv
tb/adi_density_checker.sv
tb/atmosphere_density_interp_core_test.sv
